// File: rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned BlkIdxW  = 8;
  localparam int unsigned PageCntW = 7;
  localparam int unsigned PageNumW = 6;
  localparam int unsigned CountW   = 9;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [CountW-1:0] BlocksReset = 9'd256;

  // register select is paddr[2]: byte address 0 holds blocks_in_use
  localparam logic RegBlocksInUse = 1'b0;

  // item kind codes
  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [2:0] {
    StGranted = 3'd0,
    StNoSpace = 3'd1,
    StFreed   = 3'd2,
    StAlready = 3'd3,
    StRange   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RdIdx,
    RdZero,
    RdNext
  } rd_sel_e;

  typedef enum logic [2:0] {
    ResNone,
    ResFreeRange,
    ResCountBad,
    ResNoSpace,
    ResAlready,
    ResFreed,
    ResGrant
  } res_e;

  typedef struct packed {
    logic    ld_item;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    ld_word;
    logic    wr_en;
    res_e    res;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic free_range;
    logic bad_count;
    logic no_space;
    logic used_bit;
    logic cand_any;
    logic last_page;
  } sts_t;

endpackage

// File: rtl/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bpa_ctrl.sv
// Sequencer for the allocator: accepts items, steps the row scan and picks results.
// Depends on bpa_pkg for the command and status structs.
`timescale 1ns / 1ps

module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    SIdle,
    SFreeRd,
    SAllocRd,
    SScan
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          if (sts_i.kind == bpa_pkg::KindFree) begin
            if (sts_i.free_range) begin
              cmd_o.res = bpa_pkg::ResFreeRange;
            end else begin
              cmd_o.ld_item = 1'b1;
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = bpa_pkg::RdIdx;
              state_d       = SFreeRd;
            end
          end else if (sts_i.bad_count) begin
            cmd_o.res = bpa_pkg::ResCountBad;
          end else if (sts_i.no_space) begin
            cmd_o.res = bpa_pkg::ResNoSpace;
          end else begin
            cmd_o.ld_item = 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = bpa_pkg::RdZero;
            state_d       = SAllocRd;
          end
        end
      end
      SFreeRd: begin
        if (sts_i.used_bit) begin
          cmd_o.res   = bpa_pkg::ResFreed;
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.res = bpa_pkg::ResAlready;
        end
        state_d = SIdle;
      end
      SAllocRd: begin
        cmd_o.ld_word = 1'b1;
        state_d       = SScan;
      end
      SScan: begin
        if (sts_i.cand_any) begin
          cmd_o.res = bpa_pkg::ResGrant;
          if (sts_i.last_page) begin
            cmd_o.wr_en = 1'b1;
            state_d     = SIdle;
          end
        end else begin
          // row exhausted: write it back and fetch the next one
          cmd_o.wr_en  = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bpa_pkg::RdNext;
          state_d      = SAllocRd;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != SIdle);
    end
  end

  assign busy_o = busy_q;

`ifndef SYNTHESIS
  a_busy_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == (state_q != SIdle))
    else $error("busy out of step with controller state");

  a_alloc_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && start_i && sts_i.kind == bpa_pkg::KindAlloc && !sts_i.bad_count
     && !sts_i.no_space)
    |=> (state_q == SAllocRd))
    else $error("accepted allocation did not start the row scan");
`endif

endmodule

// File: rtl/bpa_datapath.sv
// Bitmap rows, used count, blocks_in_use register, first-free finder and result registers.
// Depends on bpa_pkg and bpa_ram.
`timescale 1ns / 1ps

module bpa_datapath #(
  parameter int unsigned NUM_BLOCKS = 256,
  parameter int unsigned MAX_PAGES  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                kind_i,
  input  logic [bpa_pkg::PageCntW-1:0]        page_count_i,
  input  logic [bpa_pkg::BlkIdxW-1:0]         block_index_i,
  input  logic                                cfg_we_i,
  input  logic [bpa_pkg::CountW-1:0]          cfg_wdata_i,
  output logic [bpa_pkg::CountW-1:0]          cfg_value_o,
  input  bpa_pkg::cmd_t                       cmd_i,
  output bpa_pkg::sts_t                       sts_o,
  output logic                                res_valid_o,
  output logic [bpa_pkg::BlkIdxW-1:0]         res_block_o,
  output logic [bpa_pkg::PageNumW-1:0]        res_page_o,
  output logic                                res_last_o,
  output bpa_pkg::status_e                    res_status_o,
  output logic [bpa_pkg::CountW-1:0]          res_free_o
);

  localparam int unsigned RowBits = (NUM_BLOCKS >= 16) ? 16 : 8;
  localparam int unsigned BitW    = $clog2(RowBits);
  localparam int unsigned Rows    = (NUM_BLOCKS + RowBits - 1) / RowBits;
  localparam int unsigned RowW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned NbW     = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CmpA    = (NbW > bpa_pkg::CountW) ? NbW : bpa_pkg::CountW;
  localparam int unsigned CmpW    = (CmpA > RowW + BitW) ? CmpA : RowW + BitW;
  localparam int unsigned MaxUsed = (NUM_BLOCKS < 511) ? NUM_BLOCKS : 511;

  logic [bpa_pkg::CountW-1:0]   blocks_q;
  logic [bpa_pkg::CountW-1:0]   used_q, used_d;
  logic [bpa_pkg::PageCntW-1:0] cnt_q;
  logic [bpa_pkg::PageCntW-1:0] page_q;
  logic [bpa_pkg::BlkIdxW-1:0]  idx_q;
  logic [RowW-1:0]              row_q, row_d;
  logic [RowBits-1:0]           word_q;
  logic [Rows-1:0]              rowv_q;
  logic                         rvalid_q;

  logic [RowBits-1:0]           ram_rdata, rdata_eff, wdata;
  logic [RowBits-1:0]           elig, cand, onehot;
  logic [BitW-1:0]              first, bit_sel;
  logic [bpa_pkg::CountW-1:0]   n_eff, free_now, free_after;

  logic                         res_valid_q;
  logic [bpa_pkg::BlkIdxW-1:0]  res_block_q, res_block_d;
  logic [bpa_pkg::PageNumW-1:0] res_page_q, res_page_d;
  logic                         res_last_q, res_last_d;
  bpa_pkg::status_e             res_status_q, res_status_d;
  logic [bpa_pkg::CountW-1:0]   res_free_q;

  // effective block count: min(blocks_in_use, NUM_BLOCKS)
  assign n_eff = (CmpW'(blocks_q) < CmpW'(NUM_BLOCKS)) ? blocks_q
                                                        : bpa_pkg::CountW'(NUM_BLOCKS);
  assign free_now = (n_eff > used_q) ? n_eff - used_q : '0;

  assign rdata_eff = rvalid_q ? ram_rdata : '0;
  assign bit_sel   = idx_q[BitW-1:0];

  // bits of the current row that lie inside the managed range
  always_comb begin
    for (int j = 0; j < RowBits; j++) begin
      elig[j] = (CmpW'({row_q, BitW'(j)}) < CmpW'(n_eff));
    end
  end

  assign cand = ~word_q & elig;

  always_comb begin
    first = '0;
    for (int j = RowBits - 1; j >= 0; j--) begin
      if (cand[j]) begin
        first = BitW'(j);
      end
    end
  end

  assign onehot = RowBits'(1) << first;

  always_comb begin
    unique case (cmd_i.rd_sel)
      bpa_pkg::RdIdx:  row_d = RowW'(block_index_i >> BitW);
      bpa_pkg::RdZero: row_d = '0;
      bpa_pkg::RdNext: row_d = row_q + 1'b1;
      default:         row_d = row_q;
    endcase
  end

  always_comb begin
    if (cmd_i.res == bpa_pkg::ResFreed) begin
      wdata = rdata_eff & ~(RowBits'(1) << bit_sel);
    end else if (cmd_i.res == bpa_pkg::ResGrant) begin
      wdata = word_q | onehot;
    end else begin
      wdata = word_q;
    end
  end

  always_comb begin
    if (cmd_i.res == bpa_pkg::ResGrant) begin
      used_d = used_q + 1'b1;
    end else if (cmd_i.res == bpa_pkg::ResFreed && used_q != '0) begin
      used_d = used_q - 1'b1;
    end else begin
      used_d = used_q;
    end
  end

  assign free_after = (n_eff > used_d) ? n_eff - used_d : '0;

  always_comb begin
    res_block_d  = '0;
    res_page_d   = '0;
    res_last_d   = 1'b1;
    res_status_d = bpa_pkg::StRange;
    unique case (cmd_i.res)
      bpa_pkg::ResFreeRange: res_block_d = block_index_i;
      bpa_pkg::ResCountBad:  res_status_d = bpa_pkg::StRange;
      bpa_pkg::ResNoSpace:   res_status_d = bpa_pkg::StNoSpace;
      bpa_pkg::ResAlready: begin
        res_block_d  = idx_q;
        res_status_d = bpa_pkg::StAlready;
      end
      bpa_pkg::ResFreed: begin
        res_block_d  = idx_q;
        res_status_d = bpa_pkg::StFreed;
      end
      bpa_pkg::ResGrant: begin
        res_block_d  = bpa_pkg::BlkIdxW'({row_q, first});
        res_page_d   = page_q[bpa_pkg::PageNumW-1:0];
        res_last_d   = (page_q + 1'b1 == cnt_q);
        res_status_d = bpa_pkg::StGranted;
      end
      default: res_status_d = bpa_pkg::StRange;
    endcase
  end

  bpa_ram #(
    .WIDTH (RowBits),
    .DEPTH (Rows)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (row_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (row_d),
    .rdata_o (ram_rdata)
  );

  // control state; a row never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q    <= bpa_pkg::BlocksReset;
      used_q      <= '0;
      rowv_q      <= '0;
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blocks_q <= cfg_wdata_i;
      end
      used_q      <= used_d;
      res_valid_q <= (cmd_i.res != bpa_pkg::ResNone);
      if (cmd_i.rd_en) begin
        rvalid_q <= rowv_q[row_d];
      end
      if (cmd_i.wr_en) begin
        rowv_q[row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      cnt_q  <= page_count_i;
      idx_q  <= block_index_i;
      page_q <= '0;
    end else if (cmd_i.res == bpa_pkg::ResGrant) begin
      page_q <= page_q + 1'b1;
    end
    if (cmd_i.rd_en) begin
      row_q <= row_d;
    end
    if (cmd_i.ld_word) begin
      word_q <= rdata_eff;
    end else if (cmd_i.res == bpa_pkg::ResGrant) begin
      word_q <= word_q | onehot;
    end
    if (cmd_i.res != bpa_pkg::ResNone) begin
      res_block_q  <= res_block_d;
      res_page_q   <= res_page_d;
      res_last_q   <= res_last_d;
      res_status_q <= res_status_d;
      res_free_q   <= free_after;
    end
  end

  assign sts_o.kind       = kind_i;
  assign sts_o.free_range = ({1'b0, block_index_i} >= n_eff);
  assign sts_o.bad_count  = (page_count_i == '0) ||
                            (page_count_i > bpa_pkg::PageCntW'(MAX_PAGES));
  assign sts_o.no_space   = ({2'b00, page_count_i} > free_now);
  assign sts_o.used_bit   = rdata_eff[bit_sel];
  assign sts_o.cand_any   = (cand != '0);
  assign sts_o.last_page  = (page_q + 1'b1 == cnt_q);

  assign cfg_value_o  = blocks_q;
  assign res_valid_o  = res_valid_q;
  assign res_block_o  = res_block_q;
  assign res_page_o   = res_page_q;
  assign res_last_o   = res_last_q;
  assign res_status_o = res_status_q;
  assign res_free_o   = res_free_q;

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= bpa_pkg::CountW'(MaxUsed))
    else $error("used count beyond the blocks that can be granted");

  a_grant_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q == bpa_pkg::StGranted) |-> (used_q == $past(used_q) + 1'b1))
    else $error("grant beat without a used count step");
`endif

endmodule

// File: rtl/bitmap_page_allocator_core.sv
// Bitmap first-fit page allocator: frees one block or grants the lowest free blocks.
// Steps: a reject (free out of range, bad count, no space) is decided in the accept cycle;
// a free reads the block's row (SFreeRd) and clears its bit if set; a grant reads row 0
// (SAllocRd), then grants one page per cycle from SScan, except that a row with no free
// block (16 blocks per row, 8 if NUM_BLOCKS < 16) is written back and the next row read first.
// Reset: every block free via per-row valid flops, blocks_in_use = 256; results never stall.
`timescale 1ns / 1ps

module bitmap_page_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 256,
  parameter int unsigned MAX_PAGES  = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [bpa_pkg::PageCntW-1:0]    page_count_i,
  input  logic [bpa_pkg::BlkIdxW-1:0]     block_index_i,
  output logic                            result_valid_o,
  output logic [bpa_pkg::BlkIdxW-1:0]     granted_block_o,
  output logic [bpa_pkg::PageNumW-1:0]    page_number_o,
  output logic                            last_o,
  output logic [2:0]                      status_o,
  output logic [bpa_pkg::CountW-1:0]      free_blocks_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpa_pkg::ApbAddrW-1:0]    paddr,
  input  logic [bpa_pkg::ApbDataW-1:0]    pwdata,
  output logic [bpa_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  bpa_pkg::cmd_t              cmd;
  bpa_pkg::sts_t              sts;
  bpa_pkg::status_e           res_status;
  logic                       cfg_we;
  logic [bpa_pkg::CountW-1:0] cfg_value;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bpa_pkg::RegBlocksInUse);
  assign prdata = (paddr[2] == bpa_pkg::RegBlocksInUse)
                  ? {{(bpa_pkg::ApbDataW - bpa_pkg::CountW){1'b0}}, cfg_value} : '0;

  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  bpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_PAGES  (MAX_PAGES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .page_count_i  (page_count_i),
    .block_index_i (block_index_i),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[bpa_pkg::CountW-1:0]),
    .cfg_value_o   (cfg_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_valid_o   (result_valid_o),
    .res_block_o   (granted_block_o),
    .res_page_o    (page_number_o),
    .res_last_o    (last_o),
    .res_status_o  (res_status),
    .res_free_o    (free_blocks_o)
  );

  assign status_o = res_status;

endmodule
